// File: rtl/mcst_pkg.sv
// Package for the segment trial engine: commands, config indexes, FSM states,
// table sizes and generator constants. No dependencies.
package mcst_pkg;

  typedef enum logic [1:0] {
    CMD_WR_BIN   = 2'd0,
    CMD_WR_SPLIT = 2'd1,
    CMD_RUN      = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_SEG_COUNT = 3'd0,
    CFG_START_SEG = 3'd1,
    CFG_START_TIME = 3'd2,
    CFG_GOAL_TIME = 3'd3,
    CFG_TH_EN     = 3'd4,
    CFG_SEED      = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM,
    ST_MIX1,
    ST_MIX2,
    ST_READ,
    ST_ACC,
    ST_DONE
  } state_t;

  // table sizes; the bin pick takes the top bits of the draw, so BINS is a power of two
  localparam int MAX_SEGMENTS = 16;
  localparam int BINS = 256;

  localparam logic [63:0] MIX_MULT  = 64'h2545F4914F6CDD1F;
  localparam logic [63:0] SEED_XOR0 = 64'h6A09E667F3BCC908;
  localparam logic [63:0] SEED_XOR1 = 64'hBB67AE8584CAA73B;
  localparam int unsigned WARM_DRAWS = 10;

endpackage

// File: rtl/monte_carlo_segment_trial.sv
// Top level of the segment trial engine: control FSM, generator, time table
// memory, threshold memory. Depends on mcst_pkg.
//
// Usage: table loads and trial runs enter on the in_ channel (valid/ready).
// A load (command 0 or 1) is written to its table and returns nothing.
// A run (command 2) produces one transaction on the out_ channel.
// Each segment of a run passes through the first mix product (together with the
// generator step), the second mix product, one synchronous table read and one
// accumulate/compare. The mix products keep the low 64 bits, built from
// 32-bit partial products. When a run ends (after its last segment, on a
// split time overrun, or at once for an empty run), the done state loads the
// result into the output register and the block returns to idle.
// The result sits in an output register; the next item is accepted while
// it waits, and a run waits only if the previous result is still unread.
// Writing the seed register starts ten warm-up draws; input and config are
// held off meanwhile. Reset (rst_n low, synchronous) loads register defaults
// and runs the warm-up from seed 0.
// Tables are undefined until written.
module monte_carlo_segment_trial (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_segment,
  input  logic [7:0]  in_bin,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reached_goal,
  output logic        out_completed_all,
  output logic [31:0] out_elapsed_time,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import mcst_pkg::*;

  localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int BW = $clog2(BINS);
  localparam int AW = SW + BW;

  // registers
  logic [4:0]  seg_count_r, start_seg_r;
  logic [31:0] start_time_r, goal_r;
  logic        th_en_r;
  logic [63:0] s0_r, s1_r, s0_nxt, s1_nxt;
  logic [63:0] mix_r, mix_nxt;
  logic [3:0]  warm_r, warm_nxt;
  logic [5:0]  seg_r, seg_nxt, cnt_eff;
  logic [32:0] t_r, t_nxt;
  state_t      st_r, st_nxt;
  logic        ov_r, ov_nxt, pb_r, pb_nxt, done_r, done_nxt;
  logic [31:0] oel_r, oel_nxt;
  logic        warm_start;

  logic [31:0] tab_mem [2**AW];
  logic [31:0] th_mem [MAX_SEGMENTS];
  logic [31:0] tab_q, th_q;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] seg_idx;

  cmd_t cmd;
  assign cmd = cmd_t'(in_command);
  assign cfg_ready = (st_r == ST_IDLE);
  assign in_ready  = (st_r == ST_IDLE) && !(cfg_valid && cfg_index == CFG_SEED)
                     && !(ov_r && !out_ready && cmd == CMD_RUN);
  assign warm_start = cfg_valid && cfg_ready && cfg_index == CFG_SEED;

  assign cnt_eff = (seg_count_r > 5'(MAX_SEGMENTS)) ? 6'(MAX_SEGMENTS)
                                                     : {1'b0, seg_count_r};
  assign seg_idx = seg_r[SW-1:0];

  // mix stage 1: (a+b)*M, stage 2: (r^r>>13)*M ; 64-bit low product in 32-bit parts
  function automatic logic [63:0] mul_lo(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p0;
    logic [31:0] p1, p2;
    p0 = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    p1 = a[31:0] * b[63:32];
    p2 = a[63:32] * b[31:0];
    return p0 + {p1 + p2, 32'd0};
  endfunction

  logic [63:0] draw;
  logic [BW-1:0] bin_pick;
  assign draw = mix_r ^ (mix_r >> 27);
  // floor((draw>>11)*BINS/2^53) is the top log2(BINS) bits for power-of-two BINS
  assign bin_pick = draw[63 -: BW];
  assign rd_addr = {seg_idx, bin_pick};

  // memories
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && cmd == CMD_WR_BIN &&
        32'(in_segment) < 32'(MAX_SEGMENTS) && 32'(in_bin) < 32'(BINS))
      tab_mem[{in_segment[SW-1:0], in_bin[BW-1:0]}] <= in_value;
    if (in_valid && in_ready && cmd == CMD_WR_SPLIT &&
        32'(in_segment) + 1 < 32'(MAX_SEGMENTS))
      th_mem[in_segment[SW-1:0]] <= in_value;
    tab_q <= tab_mem[rd_addr];
    th_q  <= th_mem[seg_idx];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (warm_start) st_nxt = ST_WARM;
        else if (in_valid && in_ready && cmd == CMD_RUN) begin
          if ({1'b0, start_seg_r} >= cnt_eff) st_nxt = ST_DONE;
          else st_nxt = ST_MIX1;
        end
      end
      ST_WARM: st_nxt = (warm_r == 4'd0) ? ST_IDLE : ST_WARM;
      ST_MIX1: st_nxt = ST_MIX2;
      ST_MIX2: st_nxt = ST_READ;
      ST_READ: st_nxt = ST_ACC;
      ST_ACC: begin
        if (seg_r + 6'd1 >= cnt_eff || (th_en_r && th_q < goal_r && t_nxt[31:0] > th_q))
          st_nxt = ST_DONE;
        else st_nxt = ST_MIX1;
      end
      ST_DONE: st_nxt = (!ov_r || out_ready) ? ST_IDLE : ST_DONE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    s0_nxt = s0_r; s1_nxt = s1_r; mix_nxt = mix_r; warm_nxt = warm_r;
    seg_nxt = seg_r; t_nxt = t_r; pb_nxt = pb_r; done_nxt = done_r;
    ov_nxt = ov_r && !out_ready; oel_nxt = oel_r;
    case (st_r)
      ST_IDLE: begin
        if (warm_start) begin
          s0_nxt = cfg_data ^ SEED_XOR0;
          s1_nxt = cfg_data ^ SEED_XOR1;
          warm_nxt = 4'(WARM_DRAWS - 1);
        end else if (in_valid && in_ready && cmd == CMD_RUN) begin
          seg_nxt = {1'b0, start_seg_r};
          t_nxt = {1'b0, start_time_r};
          pb_nxt = 1'b0; done_nxt = 1'b1;
        end
      end
      ST_WARM: begin
        // warm-up draws only advance state
        s0_nxt = s1_r ^ (s1_r << 5) ^ (s1_r << 13);
        s1_nxt = (s0_r ^ s1_r) + s1_r;
        warm_nxt = warm_r - 4'd1;
      end
      ST_MIX1: begin
        mix_nxt = mul_lo(s0_r + s1_r, MIX_MULT);
        s0_nxt = s1_r ^ (s1_r << 5) ^ (s1_r << 13);
        s1_nxt = (s0_r ^ s1_r) + s1_r;
      end
      ST_MIX2: mix_nxt = mul_lo(mix_r ^ (mix_r >> 13), MIX_MULT);
      ST_READ: ;
      ST_ACC: begin
        t_nxt = t_r + {1'b0, tab_q};
        if (t_nxt[32]) t_nxt = 33'h0FFFFFFFF;
        if (seg_r + 6'd1 >= cnt_eff) pb_nxt = t_nxt[31:0] < goal_r;
        else if (th_en_r && th_q < goal_r && t_nxt[31:0] > th_q) done_nxt = 1'b0;
        seg_nxt = seg_r + 6'd1;
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          oel_nxt = t_r[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_WARM;
      seg_count_r <= 5'd16; start_seg_r <= '0; start_time_r <= '0;
      goal_r <= '1; th_en_r <= 1'b1;
      s0_r <= SEED_XOR0; s1_r <= SEED_XOR1;
      warm_r <= 4'(WARM_DRAWS - 1);
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
      s0_r <= s0_nxt; s1_r <= s1_nxt; warm_r <= warm_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SEG_COUNT:  seg_count_r <= cfg_data[4:0];
          CFG_START_SEG:  start_seg_r <= cfg_data[4:0];
          CFG_START_TIME: start_time_r <= cfg_data[31:0];
          CFG_GOAL_TIME:  goal_r <= cfg_data[31:0];
          CFG_TH_EN:      th_en_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
    mix_r <= mix_nxt; seg_r <= seg_nxt; t_r <= t_nxt;
    pb_r <= pb_nxt; done_r <= done_nxt; oel_r <= oel_nxt;
    if (st_r == ST_DONE && (!ov_r || out_ready)) begin
      out_reached_goal <= pb_r;
      out_completed_all <= done_r;
    end
  end

  assign out_valid = ov_r;
  assign out_elapsed_time = oel_r;
endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for monte_carlo_segment_trial: table loads, trial runs,
// register settings, random idling on both channels. Depends on mcst_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
  import mcst_pkg::*;

  localparam int NSEG = 16;
  localparam int NBIN = 256;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        reached;
    logic        complete;
    logic [31:0] elapsed;
  } trial_res_t;

  typedef struct {
    cmd_t        cmd;
    logic [3:0]  seg;
    logic [7:0]  bin;
    logic [31:0] val;
    logic        has_fixed;
    trial_res_t  fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = '0;
  logic [3:0] in_segment = '0;
  logic [7:0] in_bin = '0;
  logic [31:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_reached_goal;
  logic out_completed_all;
  logic [31:0] out_elapsed_time;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  always #10 clk = ~clk;

  monte_carlo_segment_trial u_dut (.*);

  // predictor state
  logic [4:0]  m_seg_count;
  logic [4:0]  m_start_seg;
  logic [31:0] m_start_time;
  logic [31:0] m_goal;
  logic        m_th_en;
  logic [63:0] gen_s0, gen_s1;
  logic [31:0] bin_time [NSEG*NBIN];
  logic [31:0] split_th [NSEG-1];

  trial_res_t expected_trials[$];
  int  mismatch_cnt = 0;
  bit  hold_off = 1'b0;
  longint unsigned cycle_cnt = 0;

  function automatic logic [63:0] gen_next();
    logic [63:0] a, b, r;
    a = gen_s0;
    b = gen_s1;
    r = (a + b) * MIX_MULT;
    r = (r ^ (r >> 13)) * MIX_MULT;
    r = r ^ (r >> 27);
    a = a ^ b;
    gen_s0 = b ^ (b << 5) ^ (b << 13);
    gen_s1 = a + b;
    return r;
  endfunction

  function automatic void gen_reseed(logic [63:0] seed);
    gen_s0 = seed ^ SEED_XOR0;
    gen_s1 = seed ^ SEED_XOR1;
    for (int i = 0; i < 10; i++) void'(gen_next());
  endfunction

  function automatic void model_cfg(cfg_idx_t idx, logic [63:0] d);
    case (idx)
      CFG_SEG_COUNT:  m_seg_count = d[4:0];
      CFG_START_SEG:  m_start_seg = d[4:0];
      CFG_START_TIME: m_start_time = d[31:0];
      CFG_GOAL_TIME:  m_goal = d[31:0];
      CFG_TH_EN:      m_th_en = d[0];
      CFG_SEED:       gen_reseed(d);
      default: ;
    endcase
  endfunction

  // returns 1 when a trial result is produced
  function automatic bit run_segments(cmd_t c, logic [3:0] s, logic [7:0] b,
                                      logic [31:0] v, output trial_res_t res);
    int cnt;
    logic [32:0] t;
    logic [63:0] x;
    logic [7:0] idx;
    res = '0;
    case (c)
      CMD_WR_BIN: begin
        bin_time[s*NBIN + b] = v;
        return 0;
      end
      CMD_WR_SPLIT: begin
        if (s < NSEG-1) split_th[s] = v;
        return 0;
      end
      CMD_RUN: ;
      default: return 0;
    endcase
    cnt = (m_seg_count > NSEG) ? NSEG : int'(m_seg_count);
    t = {1'b0, m_start_time};
    res.complete = 1'b1;
    for (int j = m_start_seg; j < cnt; j++) begin
      x = gen_next() >> 11;
      idx = x[52:45];  // BINS = 2^8: top 8 of 53 bits
      t = t + bin_time[j*NBIN + idx];
      if (t[32]) t = 33'hFFFFFFFF;
      if (j + 1 < cnt) begin
        if (m_th_en && split_th[j] < m_goal && t[31:0] > split_th[j]) begin
          res.complete = 1'b0;
          break;
        end
      end else if (t[31:0] < m_goal) begin
        res.reached = 1'b1;
      end
    end
    res.elapsed = t[31:0];
    return 1;
  endfunction

  // valid stays high from one transaction to the next on the same channel unless a
  // random gap before an item drops it; the other channel, or wait_drain, also drops it
  task automatic cfg_write(cfg_idx_t idx, logic [63:0] d);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    model_cfg(idx, d);
  endtask

  task automatic send_item(cmd_t c, logic [3:0] s, logic [7:0] b, logic [31:0] v,
                           bit has_fixed, trial_res_t fixed);
    trial_res_t res;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 19));
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_segment <= s;
    in_bin <= b;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    if (run_segments(c, s, b, v, res)) begin
      if (has_fixed && res != fixed)
        $display("note: predictor disagrees with directed row exp=%p", fixed);
      expected_trials.push_back(has_fixed ? fixed : res);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_trials.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // random time that avoids splits tripping too often
  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 5))
      0: return 32'hFFFFFFFF;
      1: return 32'h0;
      2: return $urandom;
      default: return $urandom_range(0, 5000);
    endcase
  endfunction

  task automatic load_tables();
    for (int sg = 0; sg < NSEG; sg++)
      for (int bn = 0; bn < NBIN; bn++)
        send_item(CMD_WR_BIN, 4'(sg), 8'(bn), (sg == 15 && bn == 255) ? 32'hFFFFFFFF :
                  $urandom_range(0, 5000), 1'b0, '0);
    for (int sp = 0; sp < NSEG-1; sp++)
      send_item(CMD_WR_SPLIT, 4'(sp), 8'd0, $urandom_range(2000, 60000), 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      trial_res_t got, exp_r;
      got = {out_reached_goal, out_completed_all, out_elapsed_time};
      if (expected_trials.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected transaction: %p", got);
      end else begin
        exp_r = expected_trials.pop_front();
        if (got !== exp_r) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp reached=%0b complete=%0b elapsed=%0d, got %0b %0b %0d",
                     exp_r.reached, exp_r.complete, exp_r.elapsed,
                     got.reached, got.complete, got.elapsed);
        end
      end
    end
  end

  // receiver idling
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (out_ready && out_valid) begin
        w = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 19));
        if (w > 0) out_ready <= 1'b0;
        repeat (w) @(posedge clk);
        out_ready <= !hold_off;
      end else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout");
      $display("** monte_carlo_segment_trial: FAILED **");
      $finish;
    end
  end

  stim_row_t rows[$];

  initial begin
    int k;
    m_seg_count = 16; m_start_seg = 0; m_start_time = 0;
    m_goal = 32'hFFFFFFFF; m_th_en = 1'b1;
    gen_reseed(64'h0);
    foreach (bin_time[i]) bin_time[i] = '0;
    foreach (split_th[i]) split_th[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty trial right after reset needs no tables
    cfg_write(CFG_START_SEG, 64'd16);
    cfg_write(CFG_START_TIME, 64'd1234);
    rows.push_back('{CMD_RUN, 4'd0, 8'd0, 32'd0, 1'b1, '{1'b0, 1'b1, 32'd1234}});
    rows.push_back('{CMD_NONE, 4'd15, 8'd255, 32'hFFFFFFFF, 1'b0, '0});
    rows.push_back('{CMD_WR_SPLIT, 4'd15, 8'd0, 32'h5, 1'b0, '0});  // out of range
    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].seg, rows[i].bin, rows[i].val,
                rows[i].has_fixed, rows[i].fixed);
    wait_drain();

    load_tables();
    cfg_write(CFG_START_SEG, 64'd0);
    cfg_write(CFG_START_TIME, 64'd0);
    cfg_write(CFG_SEED, 64'hFFFFFFFFFFFFFFFF);
    // saturation: near-max start time
    send_item(CMD_RUN, 4'd0, 8'd0, 32'd0, 1'b0, '0);
    cfg_write(CFG_START_TIME, 64'hFFFFFF00);
    send_item(CMD_RUN, 4'd0, 8'd0, 32'd0, 1'b0, '0);
    cfg_write(CFG_TH_EN, 64'd0);
    send_item(CMD_RUN, 4'd0, 8'd0, 32'd0, 1'b0, '0);
    cfg_write(CFG_START_TIME, 64'd0);
    cfg_write(CFG_SEG_COUNT, 64'd1);
    send_item(CMD_RUN, 4'd0, 8'd0, 32'd0, 1'b0, '0);
    cfg_write(CFG_SEG_COUNT, 64'd31);  // clamps to 16
    cfg_write(CFG_GOAL_TIME, 64'd0);
    send_item(CMD_RUN, 4'd0, 8'd0, 32'd0, 1'b0, '0);
    cfg_write(CFG_TH_EN, 64'd1);
    cfg_write(CFG_GOAL_TIME, 64'd30000);
    send_item(CMD_RUN, 4'd0, 8'd0, 32'd0, 1'b0, '0);
    wait_drain();

    // back-pressure: receiver stalls while runs pile up
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 6; i++) send_item(CMD_RUN, 4'd0, 8'd0, 32'd0, 1'b0, '0);
        in_valid <= 1'b0;
      end
    join
    wait_drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(CFG_SEG_COUNT, 64'($urandom_range(1, 31)));
      cfg_write(CFG_START_SEG, ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 31))
                                                            : 64'($urandom_range(0, 3)));
      cfg_write(CFG_START_TIME, ($urandom_range(0, 5) == 0) ? 64'($urandom)
                                                             : 64'($urandom_range(0, 3000)));
      cfg_write(CFG_GOAL_TIME, ($urandom_range(0, 5) == 0) ? 64'($urandom)
                                                            : 64'($urandom_range(5000, 80000)));
      cfg_write(CFG_TH_EN, 64'($urandom_range(0, 1)));
      cfg_write(CFG_SEED, {$urandom, $urandom});
      for (int i = 0; i < 50; i++) begin
        k = int'($urandom_range(0, 9));
        if (k < 6)
          send_item(CMD_RUN, 4'($urandom), 8'($urandom), $urandom, 1'b0, '0);
        else if (k < 8)
          send_item(CMD_WR_BIN, 4'($urandom), 8'($urandom), rand_time(), 1'b0, '0);
        else if (k < 9)
          send_item(CMD_WR_SPLIT, 4'($urandom), 8'($urandom), ($urandom_range(0, 3) == 0) ?
                    $urandom : $urandom_range(0, 60000), 1'b0, '0);
        else
          send_item(CMD_NONE, 4'($urandom), 8'($urandom), $urandom, 1'b0, '0);
      end
      wait_drain();
    end

    if (mismatch_cnt == 0 && expected_trials.size() == 0)
      $display("** monte_carlo_segment_trial: PASSED **");
    else
      $display("** monte_carlo_segment_trial: FAILED **");
    $finish;
  end

endmodule
